@@ hw/rtl/mhs_pkg.sv @@
// Shared constants of the masked height statistics block.
`timescale 1ns / 1ps
package mhs_pkg;

	localparam int HEIGHT_BITS = 18;
	localparam int MAX_PIXELS  = 1048576;
	localparam int CNT_W       = 21;
	localparam int SUM_W       = 38;
	localparam int SQ_W        = 55;
	localparam int RANGE_W     = 12;
	localparam int SCALE_W     = 24;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;

	// Serial multiplier: wide operand and shifted operand.
	localparam int MUL_W  = 76;
	localparam int MULB_W = 38;
	// Serial divider: numerator and denominator.
	localparam int DIVN_W = 40;
	localparam int DIVD_W = 22;
	// Serial square root: radicand and root.
	localparam int SQX_W = 78;
	localparam int SQR_W = 39;

	localparam logic signed [HEIGHT_BITS-1:0] HMAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
	localparam logic signed [HEIGHT_BITS-1:0] HMIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
	localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(255 * 65536);

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FLAT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STD_RANGE   = 2'd1;

endpackage

@@ hw/rtl/mhs_acc.sv @@
// Running count, sum, sum of squares, minimum and maximum of counted samples.
`timescale 1ns / 1ps
module mhs_acc import mhs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          clr,
	input  logic signed [HEIGHT_BITS-1:0] height,
	output logic signed [SUM_W-1:0]       sum,
	output logic [SQ_W-1:0]               sumsq,
	output logic [CNT_W-1:0]              count,
	output logic signed [HEIGHT_BITS-1:0] rmin,
	output logic signed [HEIGHT_BITS-1:0] rmax
);

	logic signed [2*HEIGHT_BITS-1:0] sq;
	logic                            room;

	assign sq   = height * height;
	assign room = count < CNT_W'(MAX_PIXELS);

	// Accumulate a counted sample while the count has room; clear after a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum   <= '0;
			sumsq <= '0;
			count <= '0;
			rmin  <= HMAX;
			rmax  <= HMIN;
		end else if (clr) begin
			sum   <= '0;
			sumsq <= '0;
			count <= '0;
			rmin  <= HMAX;
			rmax  <= HMIN;
		end else if (upd && room) begin
			sum   <= sum + SUM_W'(height);
			sumsq <= sumsq + SQ_W'(unsigned'(sq));
			count <= count + 1'b1;
			if (height < rmin) rmin <= height;
			if (height > rmax) rmax <= height;
		end
	end

endmodule

@@ hw/rtl/mhs_mul.sv @@
// Shift-and-add multiplier that retires one multiplier bit per cycle.
`timescale 1ns / 1ps
module mhs_mul import mhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MULB_W-1:0] op_b,
	output logic [MUL_W-1:0]  prod,
	output logic              done
);

	localparam int CW = $clog2(MULB_W);

	logic [MUL_W-1:0]  a_q;
	logic [MULB_W-1:0] b_q;
	logic [MUL_W-1:0]  prod_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MULB_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add the shifted multiplicand for each set multiplier bit.
	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= op_a;
			b_q    <= op_b;
			prod_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) prod_q <= prod_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

@@ hw/rtl/mhs_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module mhs_div import mhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIVN_W-1:0] num,
	input  logic [DIVD_W-1:0] den,
	output logic [DIVN_W-1:0] quot,
	output logic              done
);

	localparam int CW = $clog2(DIVN_W);

	logic [DIVN_W-1:0] n_q;
	logic [DIVD_W-1:0] d_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W:0]   trial;
	logic              fits;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	assign trial = {rem_q, n_q[DIVN_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in a numerator bit, subtract when the divisor fits.
	always_ff @(posedge clk) begin
		if (go) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVD_W'(trial - {1'b0, d_q});
			end else begin
				rem_q <= trial[DIVD_W-1:0];
			end
			n_q <= {n_q[DIVN_W-2:0], fits};
		end
	end

	assign quot = n_q;
	assign done = done_q;

endmodule

@@ hw/rtl/mhs_sqrt.sv @@
// Integer square root, one root bit per cycle by digit recurrence.
`timescale 1ns / 1ps
module mhs_sqrt import mhs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SQX_W-1:0] radicand,
	output logic [SQR_W-1:0] root,
	output logic             done
);

	localparam int CW = $clog2(SQR_W);
	localparam int RW = SQR_W + 2;

	logic [SQX_W-1:0] x_q;
	logic [SQR_W-1:0] root_q;
	logic [RW-1:0]    rem_q;
	logic [RW+1:0]    tmp;
	logic [RW+1:0]    trial;
	logic             fits;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	assign tmp   = {rem_q, x_q[SQX_W-1:SQX_W-2]};
	assign trial = (RW+2)'({root_q, 2'b01});
	assign fits  = tmp >= trial;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SQR_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Bring down two radicand bits and try the next root bit.
	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= RW'(tmp - trial);
			end else begin
				rem_q <= tmp[RW-1:0];
			end
			root_q <= {root_q[SQR_W-2:0], fits};
			x_q    <= x_q << 2;
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

@@ hw/rtl/masked_height_stats_stretch.sv @@
// Top level: sample accumulation, finishing sequencer and result register.
`timescale 1ns / 1ps
// Each sample word is taken while in_ready is high; a sample that is counted
// updates the count, sum, sum of squares, minimum and maximum. The word marked
// last starts a finishing pass that uses a bit-serial multiplier, divider and
// square root in turn: two 38-step products give the scaled variance, a 39-step
// root and two 40-step divisions give the rounded mean and standard deviation,
// one more 38-step product gives the bound offset and a 40-step division the
// scale. The scale division is skipped when the bounds coincide, and the pass
// may end with a wait for the output register; in_ready is low throughout.
// The result word sits in an output register, so samples of the next image
// are accepted while it waits. Configuration writes take effect at once.
module masked_height_stats_stretch import mhs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [RANGE_W-1:0]            cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [HEIGHT_BITS-1:0] height,
	input  logic [7:0]                    mask_value,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [HEIGHT_BITS-1:0] mean,
	output logic [HEIGHT_BITS-1:0]        std_dev,
	output logic signed [HEIGHT_BITS-1:0] min_height,
	output logic signed [HEIGHT_BITS-1:0] max_height,
	output logic signed [HEIGHT_BITS-1:0] low_bound,
	output logic signed [HEIGHT_BITS-1:0] high_bound,
	output logic [SCALE_W-1:0]            scale,
	output logic [CNT_W-1:0]              valid_count,
	output logic [STATUS_W-1:0]           status
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_MUL1  = 10'b00_0000_0010,
		S_MUL2  = 10'b00_0000_0100,
		S_SQRT  = 10'b00_0000_1000,
		S_DIV1  = 10'b00_0001_0000,
		S_DIV2  = 10'b00_0010_0000,
		S_MUL3  = 10'b00_0100_0000,
		S_BOUND = 10'b00_1000_0000,
		S_DIV3  = 10'b01_0000_0000,
		S_FIN   = 10'b10_0000_0000
	} state_t;

	localparam int EXT_W = HEIGHT_BITS + 6;
	localparam int DEV_W = HEIGHT_BITS + RANGE_W - 8 + 1;

	state_t state_q;
	logic   go_q;
	logic   mask_enable_q;
	logic [RANGE_W-1:0] std_range_q;

	logic accept;
	logic counted;
	logic acc_clr;
	logic signed [SUM_W-1:0]       acc_sum;
	logic [SQ_W-1:0]               acc_sq;
	logic [CNT_W-1:0]              acc_cnt;
	logic signed [HEIGHT_BITS-1:0] acc_min;
	logic signed [HEIGHT_BITS-1:0] acc_max;
	logic [SUM_W-1:0]              abs_sum;

	logic [MUL_W-1:0]  mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [MUL_W-1:0]  mul_prod;
	logic              mul_done;
	logic [DIVN_W-1:0] div_num;
	logic [DIVD_W-1:0] div_den;
	logic [DIVN_W-1:0] div_quot;
	logic              div_done;
	logic [SQR_W-1:0]  sq_root;
	logic              sq_done;

	logic [MUL_W-1:0]              p1_q;
	logic [SQX_W-1:0]              d4_q;
	logic [SQR_W-1:0]              root_q;
	logic signed [HEIGHT_BITS-1:0] mean_q;
	logic [HEIGHT_BITS-1:0]        sd_q;
	logic [DEV_W-1:0]              dev_q;
	logic signed [HEIGHT_BITS-1:0] lowb_q;
	logic signed [HEIGHT_BITS-1:0] highb_q;
	logic [HEIGHT_BITS:0]          spread_q;
	logic [SCALE_W-1:0]            scale_q;
	logic                          flat_q;

	logic signed [EXT_W-1:0] hi_ext;
	logic signed [EXT_W-1:0] lo_ext;
	logic signed [HEIGHT_BITS-1:0] hi_sat;
	logic signed [HEIGHT_BITS-1:0] lo_sat;
	logic [HEIGHT_BITS-1:0]        q_mean;
	logic                          load_out;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign counted  = !mask_enable_q || (mask_value != '0);
	assign load_out = (state_q == S_FIN) && (!out_valid || out_ready);
	assign acc_clr  = load_out;
	assign abs_sum  = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_enable_q <= 1'b0;
			std_range_q   <= RANGE_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				REG_STD_RANGE:   std_range_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	mhs_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (accept && counted),
		.clr    (acc_clr),
		.height (height),
		.sum    (acc_sum),
		.sumsq  (acc_sq),
		.count  (acc_cnt),
		.rmin   (acc_min),
		.rmax   (acc_max)
	);

	// Operand selection for the shared serial multiplier and divider.
	always_comb begin
		mul_a   = MUL_W'(acc_sq);
		mul_b   = MULB_W'(acc_cnt);
		div_num = DIVN_W'({abs_sum, 1'b0}) + DIVN_W'(acc_cnt);
		div_den = DIVD_W'({acc_cnt, 1'b0});
		case (state_q)
			S_MUL2: begin
				mul_a = MUL_W'(abs_sum);
				mul_b = MULB_W'(abs_sum);
			end
			S_MUL3: begin
				mul_a = MUL_W'(sd_q);
				mul_b = MULB_W'(std_range_q);
			end
			S_DIV2: begin
				div_num = DIVN_W'(root_q) + DIVN_W'(acc_cnt);
			end
			S_DIV3: begin
				div_num = DIVN_W'(SCALE_NUM) + DIVN_W'(spread_q >> 1);
				div_den = DIVD_W'(spread_q);
			end
			default: ;
		endcase
	end

	mhs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q && (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3)),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	mhs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q && (state_q == S_DIV1 || state_q == S_DIV2 || state_q == S_DIV3)),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	mhs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q && state_q == S_SQRT),
		.radicand (d4_q),
		.root     (sq_root),
		.done     (sq_done)
	);

	// Bounds from mean and offset, saturated to the height range.
	assign hi_ext = EXT_W'(mean_q) + EXT_W'(dev_q);
	assign lo_ext = EXT_W'(mean_q) - EXT_W'(dev_q);
	assign hi_sat = (hi_ext > EXT_W'(HMAX)) ? HMAX :
		(hi_ext < EXT_W'(HMIN)) ? HMIN : hi_ext[HEIGHT_BITS-1:0];
	assign lo_sat = (lo_ext > EXT_W'(HMAX)) ? HMAX :
		(lo_ext < EXT_W'(HMIN)) ? HMIN : lo_ext[HEIGHT_BITS-1:0];
	assign q_mean = div_quot[HEIGHT_BITS-1:0];

	// Finishing sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && last) begin
						state_q <= S_MUL1;
						go_q    <= 1'b1;
					end
				end
				S_MUL1: begin
					if (mul_done) begin
						state_q <= S_MUL2;
						go_q    <= 1'b1;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						state_q <= S_SQRT;
						go_q    <= 1'b1;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_DIV1;
						go_q    <= 1'b1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_DIV2;
						go_q    <= 1'b1;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_MUL3;
						go_q    <= 1'b1;
					end
				end
				S_MUL3: begin
					if (mul_done) state_q <= S_BOUND;
				end
				S_BOUND: begin
					if (hi_sat == lo_sat) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV3;
						go_q    <= 1'b1;
					end
				end
				S_DIV3: begin
					if (div_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Intermediate results captured as each unit finishes.
	always_ff @(posedge clk) begin
		case (state_q)
			S_MUL1: if (mul_done) p1_q <= mul_prod;
			S_MUL2: if (mul_done) d4_q <= {p1_q - mul_prod, 2'b00};
			S_SQRT: if (sq_done) root_q <= sq_root;
			S_DIV1: begin
				if (div_done) mean_q <= acc_sum[SUM_W-1] ? -q_mean : q_mean;
			end
			S_DIV2: begin
				if (div_done) begin
					sd_q <= (div_quot > DIVN_W'({HEIGHT_BITS{1'b1}})) ? {HEIGHT_BITS{1'b1}}
						: div_quot[HEIGHT_BITS-1:0];
				end
			end
			S_MUL3: begin
				if (mul_done) dev_q <= DEV_W'((mul_prod + MUL_W'(128)) >> 8);
			end
			S_BOUND: begin
				highb_q  <= hi_sat;
				lowb_q   <= lo_sat;
				spread_q <= (HEIGHT_BITS+1)'(hi_sat) - (HEIGHT_BITS+1)'(lo_sat);
				flat_q   <= hi_sat == lo_sat;
				scale_q  <= '0;
			end
			S_DIV3: begin
				if (div_done) begin
					scale_q <= (div_quot > DIVN_W'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
						: div_quot[SCALE_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Result word register; an empty image reports zeros and the sentinels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			min_height  <= acc_min;
			max_height  <= acc_max;
			valid_count <= acc_cnt;
			if (acc_cnt == '0) begin
				mean       <= '0;
				std_dev    <= '0;
				low_bound  <= '0;
				high_bound <= '0;
				scale      <= '0;
				status     <= ST_EMPTY;
			end else begin
				mean       <= mean_q;
				std_dev    <= sd_q;
				low_bound  <= lowb_q;
				high_bound <= highb_q;
				scale      <= flat_q ? '0 : scale_q;
				status     <= flat_q ? ST_FLAT : ST_OK;
			end
		end
	end

	// The last word of an image closes the input until its result is loaded.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> !in_ready)
		else $error("input still open after the last word");

	// A new result word appears only from the finishing state.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result word loaded outside the finishing state");

	// The sample count never passes the image size limit.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt <= CNT_W'(MAX_PIXELS))
		else $error("sample count beyond limit");

	// The sequencer state stays one-hot.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the masked height statistics and stretch block.
`timescale 1ns / 1ps
module tb;
	import mhs_pkg::*;

	typedef struct {
		logic signed [HEIGHT_BITS-1:0] mean;
		logic [HEIGHT_BITS-1:0]        std_dev;
		logic signed [HEIGHT_BITS-1:0] min_height;
		logic signed [HEIGHT_BITS-1:0] max_height;
		logic signed [HEIGHT_BITS-1:0] low_bound;
		logic signed [HEIGHT_BITS-1:0] high_bound;
		logic [SCALE_W-1:0]            scale;
		logic [CNT_W-1:0]              valid_count;
		logic [STATUS_W-1:0]           status;
	} image_stats_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [RANGE_W-1:0]            cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [HEIGHT_BITS-1:0] height;
	logic [7:0]                    mask_value;
	logic                          last;
	logic                          out_valid;
	logic                          out_ready;
	image_stats_t                  got;

	masked_height_stats_stretch dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.height(height), .mask_value(mask_value), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .mean(got.mean),
		.std_dev(got.std_dev), .min_height(got.min_height),
		.max_height(got.max_height), .low_bound(got.low_bound),
		.high_bound(got.high_bound), .scale(got.scale),
		.valid_count(got.valid_count), .status(got.status)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: configuration copy and running accumulators.
	logic            mask_on;
	logic [11:0]     range_q48;
	longint          acc_sum;
	longint unsigned acc_sq;
	longint unsigned acc_cnt;
	longint          acc_min;
	longint          acc_max;

	image_stats_t pending_stats[$];
	int           errors;
	int           gap_pct;
	int           stall_pct;
	int           hold_left;

	function automatic longint sat_height(longint v);
		if (v > longint'(HMAX)) return longint'(HMAX);
		if (v < longint'(HMIN)) return longint'(HMIN);
		return v;
	endfunction

	function automatic void clear_accumulators();
		acc_sum = 0;
		acc_sq  = 0;
		acc_cnt = 0;
		acc_min = longint'(HMAX);
		acc_max = longint'(HMIN);
	endfunction

	// Fold one accepted sample into the accumulators; on the last word, queue
	// the statistics the block should report.
	function automatic void predict_sample(logic signed [HEIGHT_BITS-1:0] h,
			logic [7:0] m, logic l);
		image_stats_t    r;
		longint          hv, mu, hb, lb;
		longint unsigned a, n, lo, hi, mid, sd, dev, spread, sc;
		logic [127:0]    var4, nsq, lhs, t;
		hv = longint'(h);
		if ((!mask_on || m != 8'd0) && acc_cnt < MAX_PIXELS) begin
			acc_sum += hv;
			acc_sq  += longint'(hv * hv);
			acc_cnt++;
			if (hv < acc_min) acc_min = hv;
			if (hv > acc_max) acc_max = hv;
		end
		if (!l) return;
		n = acc_cnt;
		mu = 0; sd = 0; hb = 0; lb = 0; sc = 0;
		r.status = ST_OK;
		if (n == 0) begin
			r.status = ST_EMPTY;
		end else begin
			a = (acc_sum < 0) ? longint'(-acc_sum) : longint'(acc_sum);
			mu = longint'((2 * a + n) / (2 * n));
			if (acc_sum < 0) mu = -mu;
			// Root of the variance, rounded half up, by a search on values scaled by 4*n^2.
			var4 = (128'(n) * 128'(acc_sq) - 128'(a) * 128'(a)) << 2;
			nsq = 128'(n) * 128'(n);
			lo = 0;
			hi = 64'd1 << HEIGHT_BITS;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				t = 128'(2 * mid - 1);
				lhs = t * t * nsq;
				if (lhs <= var4) lo = mid; else hi = mid - 1;
			end
			sd = (lo > (64'd1 << HEIGHT_BITS) - 1) ? (64'd1 << HEIGHT_BITS) - 1 : lo;
			dev = (sd * range_q48 + 128) >> 8;
			hb = sat_height(mu + longint'(dev));
			lb = sat_height(mu - longint'(dev));
			spread = longint'(hb - lb);
			if (spread == 0) begin
				r.status = ST_FLAT;
			end else begin
				sc = (255 * 65536 + spread / 2) / spread;
				if (sc > 24'hFFFFFF) sc = 24'hFFFFFF;
			end
		end
		r.mean        = HEIGHT_BITS'(mu);
		r.std_dev     = HEIGHT_BITS'(sd);
		r.min_height  = HEIGHT_BITS'(acc_min);
		r.max_height  = HEIGHT_BITS'(acc_max);
		r.low_bound   = HEIGHT_BITS'(lb);
		r.high_bound  = HEIGHT_BITS'(hb);
		r.scale       = SCALE_W'(sc);
		r.valid_count = CNT_W'(n);
		pending_stats.push_back(r);
		clear_accumulators();
	endfunction

	task automatic check_field(string name, longint want, longint seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			errors++;
		end
	endtask

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		image_stats_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result word, actual mean %0d", $time, got.mean);
				errors++;
			end else begin
				e = pending_stats.pop_front();
				check_field("mean", e.mean, got.mean);
				check_field("std_dev", e.std_dev, got.std_dev);
				check_field("min_height", e.min_height, got.min_height);
				check_field("max_height", e.max_height, got.max_height);
				check_field("low_bound", e.low_bound, got.low_bound);
				check_field("high_bound", e.high_bound, got.high_bound);
				check_field("scale", e.scale, got.scale);
				check_field("valid_count", e.valid_count, got.valid_count);
				check_field("status", e.status, got.status);
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one sample word and wait until it is taken.
	task automatic send_sample(logic signed [HEIGHT_BITS-1:0] h, logic [7:0] m, logic l);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < gap_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end else begin
				break;
			end
		end
		in_valid   <= 1'b1;
		height     <= h;
		mask_value <= m;
		last       <= l;
		do @(posedge clk); while (!in_ready);
		predict_sample(h, m, l);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait until every result has come and the finishing pass is surely over.
	task automatic drain();
		end_burst();
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MASK_ENABLE) mask_on = val[0];
		else if (idx == REG_STD_RANGE) range_q48 = val;
	endtask

	function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
		case ($urandom_range(5))
			0: return HMAX;
			1: return HMIN;
			2: return HEIGHT_BITS'($urandom_range(64)) - HEIGHT_BITS'(32);
			3: return HEIGHT_BITS'($urandom_range(4000)) + HEIGHT_BITS'(1000);
			default: return HEIGHT_BITS'($urandom);
		endcase
	endfunction

	// Extremes, rounding ties, empty images, flat images and saturated bounds.
	task automatic test_directed();
		gap_pct = 0;
		stall_pct = 0;
		send_sample(HMAX, 8'd0, 1'b1);
		send_sample(HMIN, 8'd255, 1'b1);
		send_sample(HMAX, 8'd1, 1'b0);
		send_sample(HMIN, 8'd1, 1'b1);
		send_sample(18'sd1, 8'd0, 1'b0);
		send_sample(18'sd2, 8'd0, 1'b1);
		send_sample(-18'sd1, 8'd0, 1'b0);
		send_sample(-18'sd2, 8'd0, 1'b1);
		send_sample(18'sd0, 8'd0, 1'b0);
		send_sample(18'sd1, 8'd0, 1'b0);
		send_sample(18'sd1, 8'd0, 1'b1);
		drain();
		write_reg(REG_MASK_ENABLE, 12'd1);
		write_reg(REG_STD_RANGE, 12'd4095);
		send_sample(HMAX, 8'd0, 1'b0);
		send_sample(HMIN, 8'd0, 1'b1);
		send_sample(HMAX, 8'h80, 1'b0);
		send_sample(HMIN, 8'h01, 1'b0);
		send_sample(18'sd5, 8'd0, 1'b1);
		send_sample(18'sd100, 8'd0, 1'b0);
		send_sample(-18'sd300, 8'd7, 1'b1);
		drain();
		write_reg(REG_STD_RANGE, 12'd0);
		send_sample(18'sd1000, 8'd9, 1'b0);
		send_sample(-18'sd1000, 8'd9, 1'b1);
		drain();
		// An index past the last register must be ignored.
		write_reg(2'd3, 12'd77);
		write_reg(REG_MASK_ENABLE, 12'd0);
		write_reg(REG_STD_RANGE, 12'd256);
	endtask

	// Random images of random length under one idling setting.
	task automatic test_random(int words, int gap, int stall);
		int sent;
		int len;
		gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < words) begin
			len = $urandom_range(24, 1);
			for (int i = 0; i < len; i++)
				send_sample(pick_height(),
					($urandom_range(2) == 0) ? 8'd0 : 8'($urandom),
					i == len - 1);
			sent += len;
		end
		drain();
	endtask

	// Hold the result side off so the output register fills and input stalls.
	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 2500;
		for (int img = 0; img < 4; img++)
			for (int i = 0; i < 6; i++)
				send_sample(pick_height(), 8'($urandom), i == 5);
		drain();
	endtask

	initial begin
		errors = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		mask_on = 1'b0;
		range_q48 = 12'd256;
		clear_accumulators();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		height = '0;
		mask_value = '0;
		last = 1'b0;
		out_ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(220, 0, 0);
		write_reg(REG_MASK_ENABLE, 12'd1);
		write_reg(REG_STD_RANGE, 12'd4095);
		test_random(220, 75, 0);
		write_reg(REG_STD_RANGE, 12'($urandom_range(4095)));
		test_random(220, 0, 75);
		write_reg(REG_MASK_ENABLE, 12'd0);
		write_reg(REG_STD_RANGE, 12'd1);
		test_random(220, 20, 20);
		write_reg(REG_STD_RANGE, 12'd256);
		test_backpressure();

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#60_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mhs_pkg.sv
hw/rtl/mhs_acc.sv
hw/rtl/mhs_mul.sv
hw/rtl/mhs_div.sv
hw/rtl/mhs_sqrt.sv
hw/rtl/masked_height_stats_stretch.sv
dv/tb.sv
